// ===== rtl/core/hcs_pkg.sv =====
// Shared types and constants for the Hamiltonian cycle search block.
package hcs_pkg;

	// Fixed geometry of the adjacency store and of the path fields.
	localparam int RowSlots = 16;
	localparam int VertexW  = 4;
	localparam int RowW     = 16;
	localparam int CountW   = 5;

	// One write into the adjacency row store.
	typedef struct packed {
		logic               en;
		logic [VertexW-1:0] addr;
		logic [RowW-1:0]    data;
	} row_wr_t;

	// One path entry as it leaves the search sequencer.
	typedef struct packed {
		logic               valid;
		logic [VertexW-1:0] vertex;
		logic               found;
		logic               last;
	} path_beat_t;

endpackage

// ===== rtl/core/hcs_row_store.sv =====
// Adjacency row store: one row written per beat, one row read by vertex.
module hcs_row_store (
	input  logic                                clk,
	input  hcs_pkg::row_wr_t                    wr,
	input  logic [hcs_pkg::VertexW-1:0]         rd_addr,
	output logic [hcs_pkg::RowW-1:0]            rd_data
);

	logic [hcs_pkg::RowW-1:0] rows_q [hcs_pkg::RowSlots];

	// Rows hold no reset value; the user must write them before they are read, as the store does not enforce this.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			rows_q[wr.addr] <= wr.data;
		end
	end

	// The sequencer reads the row of the vertex at the end of the path.
	assign rd_data = rows_q[rd_addr];

endmodule

// ===== rtl/core/hcs_search_seq.sv =====
// Backtracking sequencer: tests one candidate vertex per cycle, save in backtrack steps, then emits the path.
module hcs_search_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [hcs_pkg::CountW-1:0]          n_active,
	input  logic [hcs_pkg::RowW-1:0]            row_data,
	output logic [hcs_pkg::VertexW-1:0]         row_addr,
	output logic                                busy,
	output hcs_pkg::path_beat_t                 beat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_EMIT
	} state_t;

	state_t                        state_q;
	logic [hcs_pkg::CountW-1:0]    n_q;
	logic [hcs_pkg::CountW-1:0]    depth_q;
	logic [hcs_pkg::CountW-1:0]    cand_q;
	logic [hcs_pkg::RowW-1:0]      used_q;
	logic [hcs_pkg::VertexW-1:0]   path_q [hcs_pkg::RowSlots];
	logic [hcs_pkg::VertexW-1:0]   emit_q;
	logic                          found_q;
	hcs_pkg::path_beat_t           beat_q;

	logic [hcs_pkg::CountW-1:0]    depth_m1;
	logic [hcs_pkg::VertexW-1:0]   rd_idx;
	logic [hcs_pkg::VertexW-1:0]   path_rd;
	logic [hcs_pkg::VertexW-1:0]   target;
	logic                          full_path;
	logic                          edge_ok;
	logic                          cand_free;
	logic                          back;
	logic                          emit_last;

	// Candidate test: one path read, one row read and one bit pick per cycle.
	always_comb begin
		depth_m1  = depth_q - 5'd1;
		rd_idx    = (state_q == S_EMIT) ? emit_q : depth_m1[3:0];
		path_rd   = path_q[rd_idx];
		full_path = (depth_q >= n_q);
		target    = full_path ? '0 : cand_q[3:0];
		edge_ok   = row_data[target];
		cand_free = !used_q[target];
		back      = (full_path && !edge_ok) || (!full_path && (cand_q >= n_q));
		emit_last = (({1'b0, emit_q} + 5'd1) == n_q);
	end

	assign row_addr = path_rd;
	assign busy     = (state_q != S_IDLE);
	assign beat     = beat_q;

	// Sequencer state, search registers and the registered path beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			beat_q  <= '0;
			found_q <= 1'b0;
			depth_q <= 5'd1;
			cand_q  <= '0;
			used_q  <= '0;
			n_q     <= 5'd1;
			emit_q  <= '0;
			for (int i = 0; i < hcs_pkg::RowSlots; i++) begin
				path_q[i] <= '0;
			end
		end else begin
			if (state_q != S_EMIT) begin
				beat_q.valid <= 1'b0;
				beat_q.last  <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (go) begin
						n_q     <= n_active;
						depth_q <= 5'd1;
						cand_q  <= '0;
						used_q  <= {{(hcs_pkg::RowW-1){1'b0}}, 1'b1};
						found_q <= 1'b0;
						for (int i = 0; i < hcs_pkg::RowSlots; i++) begin
							path_q[i] <= '0;
						end
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (full_path && edge_ok) begin
						// Closing edge back to vertex zero exists.
						found_q <= 1'b1;
						emit_q  <= '0;
						state_q <= S_EMIT;
					end else if (back) begin
						if (depth_q == 5'd1) begin
							// Search exhausted; the path has been cleared to zero.
							found_q <= 1'b0;
							emit_q  <= '0;
							state_q <= S_EMIT;
						end else begin
							// Take the last vertex off the path and resume after it.
							used_q[path_rd]         <= 1'b0;
							path_q[depth_m1[3:0]]   <= '0;
							depth_q                 <= depth_m1;
							cand_q                  <= {1'b0, path_rd} + 5'd1;
						end
					end else if (edge_ok && cand_free) begin
						path_q[depth_q[3:0]] <= cand_q[3:0];
						used_q[cand_q[3:0]]  <= 1'b1;
						depth_q              <= depth_q + 5'd1;
						cand_q               <= '0;
					end else begin
						cand_q <= cand_q + 5'd1;
					end
				end
				S_EMIT: begin
					beat_q.valid  <= 1'b1;
					beat_q.vertex <= path_rd;
					beat_q.found  <= found_q;
					beat_q.last   <= emit_last;
					emit_q        <= emit_q + 4'd1;
					if (emit_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/hamiltonian_cycle_search.sv =====
// Top level of the Hamiltonian cycle search block.
//
// Usage: the graph arrives one adjacency row per beat on the command channel
// (start, row_index, row_edges, last_row); a beat is taken when start is high
// and busy is low. Each row is stored at once, and a row without last_row set
// yields no result and leaves busy low. The beat with last_row set starts a
// depth-first search from vertex zero on the next cycle; busy stays high
// through the search and falls in the cycle that shows the last path beat.
// The search sequencer tests one candidate vertex per cycle, save in backtrack
// steps, against the stored row of the vertex at the end of the path; once the
// path is full it checks the closing edge back to vertex zero. After that,
// vertex_count path beats leave on result_valid, one per cycle, from the beat
// register once the sequencer is in its emit state; the last carries
// last_of_run. The receiver cannot stall: each beat is present for one cycle.
// vertex_count is written on the cfg channel (always ready); the user must
// write it only while idle, as the block does not enforce this. Zero counts as
// one and values above the vertex limit saturate. Reset clears the sequencer
// and sets vertex_count to one; stored rows are undefined until written.
module hamiltonian_cycle_search #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [hcs_pkg::VertexW-1:0]        row_index,
	input  logic [hcs_pkg::RowW-1:0]           row_edges,
	input  logic                               last_row,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hcs_pkg::CountW-1:0]         cfg_data,
	output logic                               result_valid,
	output logic [hcs_pkg::VertexW-1:0]        vertex_index,
	output logic                               cycle_found,
	output logic                               last_of_run
);

	localparam int VertexLimit = (MAX_VERTICES < hcs_pkg::RowSlots) ?
		MAX_VERTICES : hcs_pkg::RowSlots;

	logic [hcs_pkg::CountW-1:0]  vertex_count_q;
	logic [hcs_pkg::CountW-1:0]  n_active;
	logic                        accept;
	hcs_pkg::row_wr_t            row_wr;
	logic [hcs_pkg::VertexW-1:0] row_addr;
	logic [hcs_pkg::RowW-1:0]    row_data;
	hcs_pkg::path_beat_t         beat;

	// Vertex count register; the user must write it only while the block is idle, as the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	// Clamp the count into the supported vertex range.
	always_comb begin
		if (vertex_count_q == '0) begin
			n_active = 5'd1;
		end else if (vertex_count_q > 5'(VertexLimit)) begin
			n_active = 5'(VertexLimit);
		end else begin
			n_active = vertex_count_q;
		end
	end

	// Every accepted beat stores its row.
	assign accept      = start && !busy;
	assign row_wr.en   = accept;
	assign row_wr.addr = row_index;
	assign row_wr.data = row_edges;

	hcs_row_store u_rows (
		.clk     (clk),
		.wr      (row_wr),
		.rd_addr (row_addr),
		.rd_data (row_data)
	);

	hcs_search_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept && last_row),
		.n_active (n_active),
		.row_data (row_data),
		.row_addr (row_addr),
		.busy     (busy),
		.beat     (beat)
	);

	assign result_valid = beat.valid;
	assign vertex_index = beat.vertex;
	assign cycle_found  = beat.found;
	assign last_of_run  = beat.last;

endmodule

// ===== rtl/core/hcs_checker.sv =====
// Port-level checks for the Hamiltonian cycle search block, with its bind.
module hcs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               last_row,
	input logic                               result_valid,
	input logic [hcs_pkg::VertexW-1:0]        vertex_index,
	input logic                               cycle_found,
	input logic                               last_of_run
);

	// A final row always starts a search.
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_row) |=> busy)
		else $error("final row beat did not start the search");

	// A run ends with its last beat; no stray beat follows.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |=> !result_valid)
		else $error("result beat after the last of a run");

	// Beats of one run are back to back and agree on the found flag.
	a_run_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |=>
		(result_valid && (cycle_found == $past(cycle_found))))
		else $error("run broke up or changed its found flag");

	// Without a cycle every path entry is vertex zero.
	a_no_cycle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !cycle_found) |-> (vertex_index == '0))
		else $error("nonzero vertex in a run without a cycle");

	// Only the last beat of a run may show while the block is idle.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !busy) |-> last_of_run)
		else $error("result beat while idle that is not the last");

endmodule

bind hamiltonian_cycle_search hcs_checker u_hcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_row     (last_row),
	.result_valid (result_valid),
	.vertex_index (vertex_index),
	.cycle_found  (cycle_found),
	.last_of_run  (last_of_run)
);
